>>> rtl/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the Q16.16 matrix-vector multiplier.
// ----------------------------------------------------------------------------
package mvm_pkg;

    // Parameter defaults
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 1024;

    // Field widths
    localparam int COMMAND_W      = 1;
    localparam int ELEM_INDEX_W   = 6;
    localparam int VALUE_W        = 32;
    localparam int ROW_INDEX_W    = 10;
    localparam int ROW_COUNT_W    = 11;
    localparam int COLUMN_COUNT_W = 7;
    localparam int ACC_W          = 64;
    localparam int FRAC_W         = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

    // Commands
    localparam logic [COMMAND_W-1:0] CMD_LOAD   = 1'b0;
    localparam logic [COMMAND_W-1:0] CMD_MATRIX = 1'b1;

    // Result queue, power of two
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);

    localparam logic signed [VALUE_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [COMMAND_W-1:0]        command;
        logic [ELEM_INDEX_W-1:0]     element_index;
        logic signed [VALUE_W-1:0]   element_value;
    } t_in_item;

    typedef struct packed {
        logic [ROW_INDEX_W-1:0]      row_index;
        logic signed [VALUE_W-1:0]   row_result;
        logic                        saturated;
        logic                        last_row;
    } t_out_item;

    // Per-item control carried alongside the datapath
    typedef struct packed {
        logic [ROW_INDEX_W-1:0]      row_index;
        logic                        end_row;
        logic                        last_row;
    } t_mac_ctl;

endpackage

>>> rtl/mvm_vec_store.sv
// ----------------------------------------------------------------------------
// mvm_vec_store
// Vector store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mvm_vec_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [mvm_pkg::VALUE_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [mvm_pkg::VALUE_W-1:0] o_rdata
);
    import mvm_pkg::*;

    logic [VALUE_W-1:0] r_mem [DEPTH];
    logic [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/mvm_mac.sv
// ----------------------------------------------------------------------------
// mvm_mac
// Multiply stage, 64-bit accumulate stage and Q16.16 reduction with saturation.
// ----------------------------------------------------------------------------
module mvm_mac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clear,
    input  logic                        i_valid,
    input  logic signed [mvm_pkg::VALUE_W-1:0] i_elem,
    input  logic [mvm_pkg::VALUE_W-1:0] i_vec,
    input  mvm_pkg::t_mac_ctl           i_ctl,
    output logic                        o_valid,
    output mvm_pkg::t_out_item          o_item
);
    import mvm_pkg::*;

    logic signed [VALUE_W-1:0] vec_s;
    logic signed [ACC_W-1:0]   n_prod;
    logic signed [ACC_W-1:0]   r_prod;
    logic                      r_a_valid;
    t_mac_ctl                  r_a_ctl;
    logic [ACC_W-1:0]          n_sum;
    logic [ACC_W-1:0]          r_acc;
    logic [ACC_W-1:0]          r_sum;
    logic                      r_b_valid;
    t_mac_ctl                  r_b_ctl;
    logic                      in_range;

    assign vec_s  = $signed(i_vec);
    assign n_prod = i_elem * vec_s;

    // Multiply stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= n_prod;
        r_a_ctl <= i_ctl;
    end

    // Accumulate stage: sum wraps modulo 2^64
    assign n_sum = r_acc + ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid && r_a_ctl.end_row;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_a_valid) begin
                r_acc <= r_a_ctl.end_row ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && r_a_ctl.end_row) begin
            r_sum   <= n_sum;
            r_b_ctl <= r_a_ctl;
        end
    end

    // Shift right by the fraction and clip: in range when the top bits agree
    assign in_range = (r_sum[ACC_W-1:VALUE_W+FRAC_W-1] == '0) ||
                      (r_sum[ACC_W-1:VALUE_W+FRAC_W-1] == '1);

    always_comb begin
        o_item.row_index = r_b_ctl.row_index;
        o_item.last_row  = r_b_ctl.last_row;
        o_item.saturated = !in_range;
        if (in_range) begin
            o_item.row_result = $signed(r_sum[VALUE_W+FRAC_W-1:FRAC_W]);
        end else begin
            o_item.row_result = r_sum[ACC_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign o_valid = r_b_valid;

endmodule

>>> rtl/mvm_out_fifo.sv
// ----------------------------------------------------------------------------
// mvm_out_fifo
// Result queue that decouples the datapath from the output handshake.
// ----------------------------------------------------------------------------
module mvm_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mvm_pkg::t_out_item  i_item,
    input  logic                i_pop,
    output logic                o_valid,
    output mvm_pkg::t_out_item  o_item
);
    import mvm_pkg::*;

    t_out_item         r_mem [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wr_ptr;
    logic [OUT_AW-1:0] r_rd_ptr;
    logic [OUT_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OUT_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + OUT_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (OUT_AW+1)'(1);
                2'b01:   r_count <= r_count - (OUT_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

>>> rtl/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// Q16.16 matrix times vector: vector loads into a store, matrix elements
// stream row-major, one saturated dot product per finished row.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     payload
//  in        input      i_in_valid / o_in_ready       i_in_data  (t_in_item)
//  out       output     o_out_valid / i_out_ready     o_out_data (t_out_item)
//  cfg       input      i_cfg_we                      i_cfg_index, i_cfg_wdata
//
//  One request per cycle while a result queue slot is free; the vector store is
//  read once per matrix element. A row's last element, taken with its store read,
//  then passes the multiply, accumulate and queue write before the result shows.
//  Reset is synchronous; no clearing pass is needed.
//  The result queue holds 8 rows; input stalls only when every queue slot is
//  reserved by a row already in flight or waiting on the output.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
    parameter int MAX_COLUMNS = mvm_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = mvm_pkg::DEF_MAX_ROWS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  mvm_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output mvm_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [mvm_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mvm_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import mvm_pkg::*;

    localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCNT_W = (COL_W + 1 > COLUMN_COUNT_W) ? COL_W + 1 : COLUMN_COUNT_W;
    localparam int RCNT_W = (ROW_W + 1 > ROW_COUNT_W) ? ROW_W + 1 : ROW_COUNT_W;
    localparam int IDX_W  = (CCNT_W > ELEM_INDEX_W) ? CCNT_W : ELEM_INDEX_W;

    logic               in_acc;
    logic               is_matrix;
    logic               mat_acc;
    logic               load_acc;
    logic               idx_ok;
    logic               end_row;
    logic               last_row;
    logic               cfg_restart;
    logic               out_pop;

    logic [COL_W-1:0]   r_col_pos;
    logic [COL_W-1:0]   n_col_pos;
    logic [ROW_W-1:0]   r_row_pos;
    logic [ROW_W-1:0]   n_row_pos;
    logic [COL_W-1:0]   r_col_last;
    logic [ROW_W-1:0]   r_row_last;
    logic [COL_W-1:0]   col_lim;
    logic [ROW_W-1:0]   row_lim;
    logic [CCNT_W-1:0]  ccount;
    logic [RCNT_W-1:0]  rcount;

    logic [OUT_AW:0]    r_credit;
    logic [OUT_AW:0]    n_credit;

    logic                      r_s1_valid;
    logic signed [VALUE_W-1:0] r_s1_elem;
    t_mac_ctl                  r_s1_ctl;
    t_mac_ctl                  s0_ctl;
    logic [VALUE_W-1:0]        vec_rdata;

    logic                      mac_valid;
    t_out_item                 mac_item;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign o_in_ready = (r_credit < (OUT_AW+1)'(OUT_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;
    assign is_matrix  = (i_in_data.command == CMD_MATRIX);
    assign mat_acc    = in_acc && is_matrix;
    assign idx_ok     = (IDX_W'(i_in_data.element_index) < IDX_W'(MAX_COLUMNS));
    assign load_acc   = in_acc && !is_matrix && idx_ok;
    assign end_row    = (r_col_pos == r_col_last);
    assign last_row   = (r_row_pos == r_row_last);
    assign out_pop    = o_out_valid && i_out_ready;

    assign cfg_restart = i_cfg_we &&
        ((i_cfg_index == CFG_ROW_COUNT) || (i_cfg_index == CFG_COLUMN_COUNT));

    // ------------------------------------------------------------------
    // Configuration: keep the last column and row position, clamped
    // ------------------------------------------------------------------
    always_comb begin
        ccount = CCNT_W'(i_cfg_wdata[COLUMN_COUNT_W-1:0]);
        rcount = RCNT_W'(i_cfg_wdata[ROW_COUNT_W-1:0]);
        if (ccount == '0) begin
            col_lim = '0;
        end else if (ccount > CCNT_W'(MAX_COLUMNS)) begin
            col_lim = COL_W'(MAX_COLUMNS - 1);
        end else begin
            col_lim = COL_W'(ccount - CCNT_W'(1));
        end
        if (rcount == '0) begin
            row_lim = '0;
        end else if (rcount > RCNT_W'(MAX_ROWS)) begin
            row_lim = ROW_W'(MAX_ROWS - 1);
        end else begin
            row_lim = ROW_W'(rcount - RCNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_last <= '0;
            r_row_last <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW_COUNT:    r_row_last <= row_lim;
                CFG_COLUMN_COUNT: r_col_last <= col_lim;
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Column and row positions
    // ------------------------------------------------------------------
    always_comb begin
        n_col_pos = r_col_pos;
        n_row_pos = r_row_pos;
        if (cfg_restart) begin
            n_col_pos = '0;
            n_row_pos = '0;
        end else if (mat_acc) begin
            n_col_pos = end_row ? '0 : r_col_pos + COL_W'(1);
            if (end_row) begin
                n_row_pos = last_row ? '0 : r_row_pos + ROW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
        end
    end

    // ------------------------------------------------------------------
    // Result credits: reserve a queue slot when a row's last element enters
    // ------------------------------------------------------------------
    always_comb begin
        n_credit = r_credit;
        if (mat_acc && end_row) begin
            n_credit = n_credit + (OUT_AW+1)'(1);
        end
        if (out_pop) begin
            n_credit = n_credit - (OUT_AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= n_credit;
        end
    end

    // ------------------------------------------------------------------
    // Vector store and read stage
    // ------------------------------------------------------------------
    mvm_vec_store #(
        .DEPTH (MAX_COLUMNS),
        .AW    (COL_W)
    ) u_vec_store (
        .i_clk   (i_clk),
        .i_we    (load_acc),
        .i_waddr (COL_W'(i_in_data.element_index)),
        .i_wdata (i_in_data.element_value),
        .i_re    (mat_acc),
        .i_raddr (r_col_pos),
        .o_rdata (vec_rdata)
    );

    assign s0_ctl.row_index = ROW_INDEX_W'(r_row_pos);
    assign s0_ctl.end_row   = end_row;
    assign s0_ctl.last_row  = last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= mat_acc;
        end
    end

    // Hold element and control beside the store read
    always_ff @(posedge i_clk) begin
        if (mat_acc) begin
            r_s1_elem <= i_in_data.element_value;
            r_s1_ctl  <= s0_ctl;
        end
    end

    mvm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (cfg_restart),
        .i_valid (r_s1_valid),
        .i_elem  (r_s1_elem),
        .i_vec   (vec_rdata),
        .i_ctl   (r_s1_ctl),
        .o_valid (mac_valid),
        .o_item  (mac_item)
    );

    mvm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mac_valid),
        .i_item  (mac_item),
        .i_pop   (out_pop),
        .o_valid (o_out_valid),
        .o_item  (o_out_data)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_out_has_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_credit != '0))
        else $error("result shown without a reserved slot");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (OUT_AW+1)'(OUT_DEPTH))
        else $error("result credits exceed queue depth");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col_pos <= r_col_last)
        else $error("column position past last column");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_restart |=> ((r_col_pos == '0) && (r_row_pos == '0)))
        else $error("positions not cleared after configuration write");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mat_acc && end_row && last_row && !cfg_restart) |=> (r_row_pos == '0))
        else $error("row position did not wrap after final row");

endmodule
